>>> rtl/core/ffha_pkg.sv
// Shared constants, header layout and control types of the first-fit heap allocator.
package ffha_pkg;

	localparam int unsigned HEAP_BYTES   = 65536;
	localparam int unsigned HEADER_BYTES = 24;
	localparam int unsigned GRAN         = 8;
	localparam int unsigned GRAN_SH      = $clog2(GRAN);

	// The heap is tracked in units of GRAN bytes; every block starts on such a unit.
	localparam int unsigned HEAP_UNITS = HEAP_BYTES / GRAN;
	localparam int unsigned HDR_UNITS  = HEADER_BYTES / GRAN;
	localparam int unsigned ADDR_W     = $clog2(HEAP_UNITS);
	localparam int unsigned LEN_W      = ADDR_W;
	localparam int unsigned MAX_BLOCKS = HEAP_BYTES / (HEADER_BYTES + GRAN) + 2;

	localparam int unsigned SIZE_W = 17;
	localparam int unsigned OFF_W  = 16;
	localparam int unsigned SUM_W  = 32;
	localparam int unsigned CNT_W  = 12;
	localparam int unsigned NEED_W = SIZE_W + 1 - GRAN_SH;
	localparam int unsigned CMP_W  = NEED_W + 1;

	localparam int unsigned IN_BITS  = SIZE_W + OFF_W;
	localparam int unsigned IN_W     = ((IN_BITS + 7) / 8) * 8;
	localparam int unsigned OUT_BITS = 1 + OFF_W + 2 * SUM_W + CNT_W;
	localparam int unsigned OUT_W    = ((OUT_BITS + 7) / 8) * 8;

	typedef enum logic {
		REQ_ALLOC = 1'b0,
		REQ_FREE  = 1'b1
	} req_kind_t;

	typedef struct packed {
		logic             avail;
		logic [LEN_W-1:0] len8;
	} hdr_t;

	localparam int unsigned HDR_W = $bits(hdr_t);

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_CHK,
		S_RD,
		S_ALLOC_EV,
		S_SPLIT,
		S_FREE_EV,
		S_DONE
	} state_t;

	typedef struct packed {
		logic init_wr;
		logic load_req;
		logic rd;
		logic alloc_eval;
		logic free_eval;
		logic adv;
		logic split_wr;
		logic out_load;
	} ctl_cmd_t;

	typedef struct packed {
		logic is_free;
		logic skip;
		logic fit;
		logic split;
		logic last;
		logic out_busy;
	} dp_stat_t;

endpackage

>>> rtl/core/ffha_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ffha_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/core/ffha_ctrl.sv
// Controller state machine that sequences header walks, splits and result beats.
module ffha_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  ffha_pkg::dp_stat_t stat,
	output ffha_pkg::ctl_cmd_t cmd
);

	ffha_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ffha_pkg::S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ffha_pkg::S_INIT: begin
				cmd.init_wr = 1'b1;
				state_d     = ffha_pkg::S_IDLE;
			end
			ffha_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_req = 1'b1;
					state_d      = ffha_pkg::S_CHK;
				end
			end
			ffha_pkg::S_CHK: begin
				if (stat.skip) begin
					state_d = ffha_pkg::S_DONE;
				end else begin
					state_d = ffha_pkg::S_RD;
				end
			end
			ffha_pkg::S_RD: begin
				cmd.rd = 1'b1;
				if (stat.is_free) begin
					state_d = ffha_pkg::S_FREE_EV;
				end else begin
					state_d = ffha_pkg::S_ALLOC_EV;
				end
			end
			ffha_pkg::S_ALLOC_EV: begin
				cmd.alloc_eval = 1'b1;
				priority if (stat.fit && stat.split) begin
					state_d = ffha_pkg::S_SPLIT;
				end else if (stat.fit || stat.last) begin
					state_d = ffha_pkg::S_DONE;
				end else begin
					cmd.adv = 1'b1;
					state_d = ffha_pkg::S_RD;
				end
			end
			ffha_pkg::S_SPLIT: begin
				cmd.split_wr = 1'b1;
				state_d      = ffha_pkg::S_DONE;
			end
			ffha_pkg::S_FREE_EV: begin
				cmd.free_eval = 1'b1;
				if (stat.last) begin
					state_d = ffha_pkg::S_DONE;
				end else begin
					cmd.adv = 1'b1;
					state_d = ffha_pkg::S_RD;
				end
			end
			ffha_pkg::S_DONE: begin
				if (!stat.out_busy) begin
					cmd.out_load = 1'b1;
					state_d      = ffha_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = ffha_pkg::S_IDLE;
			end
		endcase
	end

endmodule

>>> rtl/core/ffha_dp.sv
// Datapath: header memory, walk registers, running counters and the result register.
module ffha_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tuser,
	input  logic [ffha_pkg::IN_W-1:0]   s_axis_tdata,
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	output logic [ffha_pkg::OUT_W-1:0]  m_axis_tdata,
	input  ffha_pkg::ctl_cmd_t          cmd,
	output ffha_pkg::dp_stat_t          stat
);

	localparam int unsigned AW = ffha_pkg::ADDR_W;
	localparam int unsigned LW = ffha_pkg::LEN_W;

	// Request registers.
	ffha_pkg::req_kind_t          kind_q;
	logic [ffha_pkg::NEED_W-1:0]  need8_q;
	logic                         zero_q;
	logic [ffha_pkg::OFF_W-1:0]   off_q;

	// Walk and merge registers.
	logic [AW-1:0] cur8_q;
	logic [AW-1:0] run_head_q;
	logic [LW-1:0] run_len_q;
	logic          run_free_q;
	logic [AW-1:0] split_addr_q;
	logic [LW-1:0] split_len_q;

	// Result and counters.
	logic                        ok_q;
	logic [ffha_pkg::OFF_W-1:0]  where_q;
	logic [ffha_pkg::SUM_W-1:0]  alloc_sum_q;
	logic [ffha_pkg::SUM_W-1:0]  free_sum_q;
	logic [ffha_pkg::CNT_W-1:0]  blk_cnt_q;
	logic                        out_valid_q;
	logic [ffha_pkg::OUT_W-1:0]  out_data_q;

	// Memory port signals.
	logic                    ram_we;
	logic [AW-1:0]           ram_waddr;
	ffha_pkg::hdr_t          ram_wdata;
	logic [ffha_pkg::HDR_W-1:0] ram_rdata;
	ffha_pkg::hdr_t          rd_hdr;

	// Decoded input beat.
	logic [ffha_pkg::SIZE_W-1:0]  in_size;
	logic [ffha_pkg::OFF_W-1:0]   in_off;
	logic [ffha_pkg::SIZE_W:0]    size_up;
	logic [ffha_pkg::NEED_W-1:0]  in_need8;

	// Evaluation of the header just read.
	logic [ffha_pkg::OFF_W-1:0]   cur_bytes;
	logic [AW:0]                  next8;
	logic                         last;
	logic                         hit;
	logic [ffha_pkg::CMP_W-1:0]   len_x;
	logic [ffha_pkg::CMP_W-1:0]   need_x;
	logic                         fit;
	logic                         split;
	logic [LW-1:0]                grant_len;
	logic [AW-1:0]                split_addr;
	logic [LW-1:0]                split_len;
	logic                         eff_free;
	logic                         merging;
	logic [LW-1:0]                merged_len;

	ffha_ram #(
		.WIDTH (ffha_pkg::HDR_W),
		.DEPTH (ffha_pkg::HEAP_UNITS)
	) u_hdr_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (cmd.rd),
		.raddr (cur8_q),
		.rdata (ram_rdata)
	);

	assign rd_hdr = ffha_pkg::hdr_t'(ram_rdata);

	assign in_size  = s_axis_tdata[ffha_pkg::SIZE_W-1:0];
	assign in_off   = s_axis_tdata[ffha_pkg::SIZE_W+ffha_pkg::OFF_W-1:ffha_pkg::SIZE_W];
	assign size_up  = (ffha_pkg::SIZE_W+1)'(in_size) + (ffha_pkg::SIZE_W+1)'(ffha_pkg::GRAN - 1);
	assign in_need8 = ffha_pkg::NEED_W'(size_up >> ffha_pkg::GRAN_SH);

	assign cur_bytes = ffha_pkg::OFF_W'({cur8_q, {ffha_pkg::GRAN_SH{1'b0}}});
	assign next8     = {1'b0, cur8_q} + (AW+1)'(ffha_pkg::HDR_UNITS) + {1'b0, rd_hdr.len8};
	// The blocks tile the heap exactly, so the walk ends where the next header would
	// fall off the end.
	assign last      = next8 >= (AW+1)'(ffha_pkg::HEAP_UNITS);
	assign hit       = ({1'b0, cur_bytes} + (ffha_pkg::OFF_W+1)'(ffha_pkg::HEADER_BYTES))
	                   == {1'b0, off_q};

	assign len_x      = ffha_pkg::CMP_W'(rd_hdr.len8);
	assign need_x     = ffha_pkg::CMP_W'(need8_q);
	assign fit        = rd_hdr.avail && (len_x >= need_x);
	assign split      = (len_x >= need_x + ffha_pkg::CMP_W'(ffha_pkg::HDR_UNITS + 1))
	                    && (blk_cnt_q < ffha_pkg::CNT_W'(ffha_pkg::MAX_BLOCKS));
	assign grant_len  = split ? LW'(need8_q) : rd_hdr.len8;
	assign split_addr = cur8_q + AW'(ffha_pkg::HDR_UNITS) + AW'(need8_q);
	assign split_len  = rd_hdr.len8 - LW'(need8_q) - LW'(ffha_pkg::HDR_UNITS);

	// A free walk marks the addressed block and folds every run of free blocks into
	// its first header in the same pass.
	assign eff_free   = rd_hdr.avail | hit;
	assign merging    = run_free_q && eff_free;
	assign merged_len = run_len_q + LW'(ffha_pkg::HDR_UNITS) + rd_hdr.len8;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = cur8_q;
		ram_wdata = rd_hdr;
		priority if (cmd.init_wr) begin
			ram_we          = 1'b1;
			ram_waddr       = '0;
			ram_wdata.avail = 1'b1;
			ram_wdata.len8  = LW'(ffha_pkg::HEAP_UNITS - ffha_pkg::HDR_UNITS);
		end else if (cmd.alloc_eval && fit) begin
			ram_we          = 1'b1;
			ram_wdata.avail = 1'b0;
			ram_wdata.len8  = grant_len;
		end else if (cmd.split_wr) begin
			ram_we          = 1'b1;
			ram_waddr       = split_addr_q;
			ram_wdata.avail = 1'b1;
			ram_wdata.len8  = split_len_q;
		end else if (cmd.free_eval && merging) begin
			ram_we          = 1'b1;
			ram_waddr       = run_head_q;
			ram_wdata.avail = 1'b1;
			ram_wdata.len8  = merged_len;
		end else if (cmd.free_eval && hit) begin
			ram_we          = 1'b1;
			ram_wdata.avail = 1'b1;
		end else begin
			ram_we = 1'b0;
		end
	end

	always_comb begin
		stat.is_free  = (kind_q == ffha_pkg::REQ_FREE);
		stat.skip     = (kind_q == ffha_pkg::REQ_FREE) ? (off_q == '0) : zero_q;
		stat.fit      = fit;
		stat.split    = split;
		stat.last     = last;
		stat.out_busy = out_valid_q && !m_axis_tready;
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			kind_q  <= ffha_pkg::req_kind_t'(s_axis_tuser);
			need8_q <= in_need8;
			zero_q  <= (in_size == '0);
			off_q   <= in_off;
			cur8_q  <= '0;
			ok_q    <= s_axis_tuser;
			where_q <= '0;
		end
		if (cmd.adv) begin
			cur8_q <= AW'(next8);
		end
		if (cmd.alloc_eval && fit) begin
			ok_q         <= 1'b1;
			where_q      <= cur_bytes + ffha_pkg::OFF_W'(ffha_pkg::HEADER_BYTES);
			split_addr_q <= split_addr;
			split_len_q  <= split_len;
		end
		if (cmd.free_eval && !merging) begin
			run_head_q <= cur8_q;
			run_len_q  <= rd_hdr.len8;
		end else if (cmd.free_eval) begin
			run_len_q <= merged_len;
		end
		if (cmd.out_load) begin
			out_data_q <= ffha_pkg::OUT_W'({blk_cnt_q, free_sum_q, alloc_sum_q, where_q, ok_q});
		end
	end

	// Control state and counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_free_q  <= 1'b0;
			alloc_sum_q <= '0;
			free_sum_q  <= '0;
			blk_cnt_q   <= ffha_pkg::CNT_W'(1);
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_req) begin
				run_free_q <= 1'b0;
			end else if (cmd.free_eval && !merging) begin
				run_free_q <= eff_free;
			end
			if (cmd.alloc_eval && fit) begin
				alloc_sum_q <= alloc_sum_q
				               + (ffha_pkg::SUM_W'(grant_len) << ffha_pkg::GRAN_SH);
			end
			if (cmd.free_eval && hit) begin
				free_sum_q <= free_sum_q
				              + (ffha_pkg::SUM_W'(rd_hdr.len8) << ffha_pkg::GRAN_SH);
			end
			if (cmd.split_wr) begin
				blk_cnt_q <= blk_cnt_q + ffha_pkg::CNT_W'(1);
			end else if (cmd.free_eval && merging) begin
				blk_cnt_q <= blk_cnt_q - ffha_pkg::CNT_W'(1);
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule

>>> rtl/core/first_fit_heap_allocator.sv
// Top level of the first-fit heap allocator with coalescing.
//
// Requests arrive on the s_axis channel: tuser selects allocate (0) or free (1),
// tdata carries the requested size and the payload offset to free. Each request
// gives exactly one beat on m_axis with the grant flag, the payload offset of the
// granted block and the running allocated, freed and block counters.
//
// Block headers live in one memory indexed by header address in 8-byte units and
// are walked in address order: each header is read in S_RD and then evaluated in
// S_ALLOC_EV or S_FREE_EV. An allocate leaves S_IDLE for S_CHK and walks the
// headers up to the first fit, adding an S_SPLIT write when the block is split,
// before S_DONE gives its result beat. A free walks the whole heap. Allocates of
// size zero and frees of a null offset go from S_CHK straight to S_DONE. A new
// request is taken once the previous one has finished, even while its result
// beat still waits, so no request is taken while another one is being walked.
//
// After reset the S_INIT state writes the single free header; tready stays low in it.
// While m_axis stalls, the finished result is held, and a following request
// waits at its end until the output register frees up.
module first_fit_heap_allocator (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [ffha_pkg::IN_W-1:0]   s_axis_tdata,  // req_size, payload_offset, zero pad
	input  logic                        s_axis_tuser,  // req_type
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	// granted, grant_offset, bytes_allocated_total, bytes_freed_total,
	// live_block_count, zero pad
	output logic [ffha_pkg::OUT_W-1:0]  m_axis_tdata
);

	ffha_pkg::ctl_cmd_t cmd;
	ffha_pkg::dp_stat_t stat;

	ffha_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	ffha_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cmd           (cmd),
		.stat          (stat)
	);

endmodule

>>> rtl/core/ffha_checker.sv
// Port-level checker for the heap allocator and its bind to the top level.
module ffha_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        s_axis_tvalid,
	input logic                        s_axis_tready,
	input logic                        m_axis_tvalid,
	input logic                        m_axis_tready,
	input logic [ffha_pkg::OUT_W-1:0]  m_axis_tdata
);

	logic [1:0] pend_q;
	logic       in_beat;
	logic       out_beat;

	assign in_beat  = s_axis_tvalid && s_axis_tready;
	assign out_beat = m_axis_tvalid && m_axis_tready;

	// Requests taken minus results delivered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (in_beat && !out_beat) begin
			pend_q <= pend_q + 2'd1;
		end else if (out_beat && !in_beat) begin
			pend_q <= pend_q - 2'd1;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result beat changed while stalled");

	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> pend_q != 2'd0)
		else $error("result beat without an outstanding request");

	a_at_most_two: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != 2'd3)
		else $error("more than two requests outstanding");

	a_fail_offset: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[ffha_pkg::OFF_W:1] == '0)
		else $error("failed grant carries a nonzero offset");

	a_block_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |->
			m_axis_tdata[ffha_pkg::OUT_BITS-1:ffha_pkg::OUT_BITS-ffha_pkg::CNT_W] != '0)
		else $error("live block count reported as zero");

endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
